// ===== rtl/lcd4_pkg.sv =====
package lcd4_pkg;

    // Request kinds carried in the cmd field.
    typedef enum logic [1:0] {
        KIND_INIT  = 2'd0,
        KIND_CMD   = 2'd1,
        KIND_DATA  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_ENABLE_HIGH = 2'd0,
        CFG_ENABLE_LOW  = 2'd1,
        CFG_BYTE_SETTLE = 2'd2,
        CFG_POWERUP     = 2'd3
    } cfg_index_t;

    localparam logic [7:0] RST_ENABLE_HIGH = 8'd1;
    localparam logic [7:0] RST_ENABLE_LOW  = 8'd1;
    localparam logic [7:0] RST_BYTE_SETTLE = 8'd2;
    localparam logic [7:0] RST_POWERUP     = 8'd20;

    // Display controller codes and wake-up nibbles.
    localparam logic [7:0] LCD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] DISP_CLEAR_CODE  = 8'h01;
    localparam logic [3:0] WAKE_NIBBLE      = 4'h3;
    localparam logic [3:0] FOUR_BIT_NIBBLE  = 4'h2;
    localparam logic [3:0] NIBBLE_MASK      = 4'hF;

    // Extra delays after the wake-up nibbles, in ms.
    localparam logic [9:0] WAKE_FIRST_MS = 10'd5;
    localparam logic [9:0] WAKE_NEXT_MS  = 10'd1;

    // Pulse step positions.
    localparam logic [3:0] STEP_WAKE_LAST  = 4'd3;
    localparam logic [3:0] STEP_INIT_FIRST = 4'd4;
    localparam logic [3:0] STEP_INIT_LAST  = 4'd11;
    localparam logic [3:0] STEP_BYTE_LAST  = 4'd1;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] nibble;
        logic [7:0] wait_before_ms;
        logic [7:0] high_ms;
        logic [9:0] wait_after_ms;
        logic       last_pulse;
    } out_item_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic emit;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;
        logic last;
    } dp_status_t;

    // Command byte sent by init after the wake-up nibbles.
    function automatic logic [7:0] init_cmd(input logic [1:0] idx);
        logic [7:0] code;
        case (idx)
            2'd0:    code = LCD_FUNCTION_SET;
            2'd1:    code = LCD_DISPLAY_ON;
            2'd2:    code = LCD_ENTRY_MODE;
            default: code = DISP_CLEAR_CODE;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/lcd4_ctrl.sv =====
module lcd4_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  lcd4_pkg::dp_status_t  status,
    output lcd4_pkg::dp_cmd_t     cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take a request only while no pulse list is being generated.
    assign in_stall = (state_reg != ST_IDLE);
    assign cmd.load = in_valid && (state_reg == ST_IDLE);
    assign cmd.emit = (state_reg == ST_RUN) && status.out_free;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cmd.emit && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    // An accepted request starts pulse generation.
    a_load_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_RUN))
        else $error("request accepted but controller not running");

    // The final pulse returns the controller to idle.
    a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && status.last) |=> (state_reg == ST_IDLE))
        else $error("controller kept running after final pulse");

    // No pulse is produced while idle.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !cmd.emit)
        else $error("pulse emitted while idle");
`endif

endmodule

// ===== rtl/lcd4_dp.sv =====
module lcd4_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    input  lcd4_pkg::in_item_t    in_data,
    input  lcd4_pkg::dp_cmd_t     cmd,
    output lcd4_pkg::dp_status_t  status,
    output logic                  out_valid,
    input  logic                  out_stall,
    output lcd4_pkg::out_item_t   out_data
);

    logic [7:0]            enable_high_reg;
    logic [7:0]            enable_low_reg;
    logic [7:0]            byte_settle_reg;
    logic [7:0]            powerup_reg;
    lcd4_pkg::kind_t       held_kind_reg;
    logic [7:0]            held_byte_reg;
    logic [3:0]            step_reg;
    logic [3:0]            step_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    lcd4_pkg::out_item_t   out_data_reg;
    lcd4_pkg::out_item_t   pulse;

    logic                  is_init;
    logic                  in_wake;
    logic                  pulse_last;
    logic [3:0]            init_offs;
    logic [7:0]            cur_byte;
    logic [9:0]            wake_extra;
    logic [9:0]            settle_low;
    logic [9:0]            settle_end;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_high_reg <= lcd4_pkg::RST_ENABLE_HIGH;
            enable_low_reg  <= lcd4_pkg::RST_ENABLE_LOW;
            byte_settle_reg <= lcd4_pkg::RST_BYTE_SETTLE;
            powerup_reg     <= lcd4_pkg::RST_POWERUP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lcd4_pkg::CFG_ENABLE_HIGH: enable_high_reg <= cfg_data;
                lcd4_pkg::CFG_ENABLE_LOW:  enable_low_reg  <= cfg_data;
                lcd4_pkg::CFG_BYTE_SETTLE: byte_settle_reg <= cfg_data;
                lcd4_pkg::CFG_POWERUP:     powerup_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Decode the current pulse step.
    assign is_init    = (held_kind_reg == lcd4_pkg::KIND_INIT);
    assign in_wake    = is_init && (step_reg <= lcd4_pkg::STEP_WAKE_LAST);
    assign pulse_last = is_init ? (step_reg == lcd4_pkg::STEP_INIT_LAST)
                                : (step_reg == lcd4_pkg::STEP_BYTE_LAST);
    assign init_offs  = step_reg - lcd4_pkg::STEP_INIT_FIRST;

    // Byte being split into nibbles.
    always_comb
    begin
        case (held_kind_reg)
            lcd4_pkg::KIND_INIT:  cur_byte = lcd4_pkg::init_cmd(init_offs[2:1]);
            lcd4_pkg::KIND_CLEAR: cur_byte = lcd4_pkg::DISP_CLEAR_CODE;
            default:              cur_byte = held_byte_reg;
        endcase
    end

    // Extra delays that follow this pulse.
    always_comb
    begin
        wake_extra = '0;
        if (in_wake)
        begin
            if (step_reg == '0)
            begin
                wake_extra = lcd4_pkg::WAKE_FIRST_MS;
            end
            else if (step_reg != lcd4_pkg::STEP_WAKE_LAST)
            begin
                wake_extra = lcd4_pkg::WAKE_NEXT_MS;
            end
        end
    end

    // A low nibble settles once; clear and the end of init settle twice.
    assign settle_low = (!in_wake && step_reg[0]) ? {2'b00, byte_settle_reg} : '0;
    assign settle_end = (pulse_last &&
                         (is_init || held_kind_reg == lcd4_pkg::KIND_CLEAR))
                        ? {2'b00, byte_settle_reg} : '0;

    // Assemble the result for this pulse.
    always_comb
    begin
        pulse.reg_select     = (held_kind_reg == lcd4_pkg::KIND_DATA);
        pulse.high_ms        = enable_high_reg;
        pulse.wait_before_ms = (is_init && step_reg == '0) ? powerup_reg : '0;
        pulse.last_pulse     = pulse_last;
        pulse.wait_after_ms  = {2'b00, enable_low_reg} + wake_extra + settle_low + settle_end;
        if (in_wake)
        begin
            pulse.nibble = (step_reg == lcd4_pkg::STEP_WAKE_LAST)
                           ? lcd4_pkg::FOUR_BIT_NIBBLE : lcd4_pkg::WAKE_NIBBLE;
        end
        else if (!step_reg[0])
        begin
            pulse.nibble = cur_byte[7:4];
        end
        else
        begin
            pulse.nibble = cur_byte[3:0] & lcd4_pkg::NIBBLE_MASK;
        end
    end

    // Step counter.
    always_comb
    begin
        step_next = step_reg;
        if (cmd.load)
        begin
            step_next = '0;
        end
        else if (cmd.emit && !pulse_last)
        begin
            step_next = step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            held_kind_reg <= lcd4_pkg::KIND_INIT;
            held_byte_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
            if (cmd.load)
            begin
                held_kind_reg <= lcd4_pkg::kind_t'(in_data.cmd);
                held_byte_reg <= in_data.byte_value;
            end
        end
    end

    // Output register.
    assign status.out_free = !out_valid_reg || !out_stall;
    assign status.last     = pulse_last;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= pulse;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    // The step never runs past the last init pulse.
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= lcd4_pkg::STEP_INIT_LAST)
        else $error("pulse step out of range");

    // An emitted pulse shows up as a valid beat.
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted pulse not presented");

    // A byte request ends on its second pulse.
    a_byte_len: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && pulse_last && !is_init) |-> (step_reg == lcd4_pkg::STEP_BYTE_LAST))
        else $error("byte request ended on wrong pulse");
`endif

endmodule

// ===== rtl/char_lcd_4bit_write_sequencer.sv =====
// Character LCD 4-bit write sequencer.
//
// A request beat on the input channel (cmd, byte_value) turns into a list
// of enable pulses, one output beat per pulse: register select, D7..D4
// nibble, wait before EN rises, EN high time, wait after EN falls and a
// flag on the final pulse. Init gives 12 beats; command, data and clear
// give 2 beats each.
// A request is taken only while the sequencer is idle. Once it is
// accepted, the controller enters its run state and the sequencer takes
// no new request until its final pulse is emitted. The pulse generator
// emits one pulse per cycle, while the receiver does not stall, into a
// single output register.
// When the receiver stalls, the output register holds its beat and the
// generator waits; no pulse is dropped or repeated.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
// and belong only in idle time. Reset restores the default timings, clears
// the output valid and returns the sequencer to idle.
module char_lcd_4bit_write_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  lcd4_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output lcd4_pkg::out_item_t  out_data
);

    lcd4_pkg::dp_cmd_t     cmd;
    lcd4_pkg::dp_status_t  status;

    // Sequencing control.
    lcd4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Timing registers, pulse builder and output register.
    lcd4_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
